// ===== rtl/core/wfcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcd_pkg
// Shared types and constants of the wind frame CRC decoder.
// ----------------------------------------------------------------------------
package wfcd_pkg;

  // CRC-8, polynomial 0x31, seed 0xFF, no reflection, no final XOR
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  // degrees in Q9.7: raw * 360 >> 9
  localparam logic [8:0] DEG_SCALE = 9'd360;
  localparam int         DEG_SHIFT = 9;

  // byte position codes
  localparam logic [2:0] POS_DIR_LO = 3'd0;
  localparam logic [2:0] POS_DIR_HI = 3'd1;
  localparam logic [2:0] POS_DIR_CRC = 3'd2;
  localparam logic [2:0] POS_SPD_LO = 3'd3;
  localparam logic [2:0] POS_SPD_HI = 3'd4;
  localparam logic [2:0] POS_SPD_CRC = 3'd5;
  localparam logic [2:0] POS_IDLE   = 3'd6;

  // configuration register indexes
  localparam logic REG_DIR_EN = 1'b0;
  localparam logic REG_SPD_EN = 1'b1;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int OUT_DW = 48;
  localparam int OUT_UW = 3;

  typedef struct packed {
    logic dir_en;
    logic spd_en;
  } cfg_t;

  typedef struct packed {
    logic        speed_update;
    logic        direction_update;
    logic        frame_valid;
    logic [15:0] speed_value;
    logic [15:0] direction_deg_q7;
    logic [15:0] direction_raw;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/wfcd_crc8.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcd_crc8
// One-byte CRC-8 update, unrolled into an eight-step XOR network.
// ----------------------------------------------------------------------------
module wfcd_crc8 (
  input  wire logic [7:0] crc_in,
  input  wire logic [7:0] data_in,
  output logic      [7:0] crc_out
);
  import wfcd_pkg::*;

  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wfcd_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcd_cfg
// APB register file: direction and speed strobe enables.
// ----------------------------------------------------------------------------
module wfcd_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wfcd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [wfcd_pkg::CFG_DW-1:0] pwdata,
  output logic      [wfcd_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output wfcd_pkg::cfg_t                   cfg
);
  import wfcd_pkg::*;

  logic dir_en_r, dir_en_nxt;
  logic spd_en_r, spd_en_nxt;
  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  // word address bit; low byte-lane bits are not decoded
  assign reg_sel = paddr[2];

  // write decode
  always_comb begin
    dir_en_nxt = dir_en_r;
    spd_en_nxt = spd_en_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DIR_EN: dir_en_nxt = pwdata[0];
        REG_SPD_EN: spd_en_nxt = pwdata[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_en_r <= 1'b1;
      spd_en_r <= 1'b1;
    end else begin
      dir_en_r <= dir_en_nxt;
      spd_en_r <= spd_en_nxt;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DIR_EN: prdata[0] = dir_en_r;
      REG_SPD_EN: prdata[0] = spd_en_r;
      default:    ;
    endcase
  end

  assign cfg.dir_en = dir_en_r;
  assign cfg.spd_en = spd_en_r;

endmodule
`default_nettype wire

// ===== rtl/core/wfcd_framer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcd_framer
// Byte position tracking, word assembly and CRC checks for one frame.
// ----------------------------------------------------------------------------
module wfcd_framer (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic [7:0]     byte_in,
  input  wire logic           frame_start,
  input  wire wfcd_pkg::cfg_t cfg,
  output logic                res_vld,
  output wfcd_pkg::result_t   res
);
  import wfcd_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] dir_r, dir_nxt;
  logic [15:0] spd_r, spd_nxt;
  logic        dir_good_r, dir_good_nxt;
  logic [2:0]  pos;
  logic [7:0]  crc_seed;
  logic [7:0]  crc_upd;
  logic [24:0] deg_prod;
  logic        valid;

  // frame_start resyncs to the first byte
  assign pos = frame_start ? POS_DIR_LO : pos_r;

  // low bytes restart the CRC, high bytes continue it
  assign crc_seed = ((pos == POS_DIR_LO) || (pos == POS_SPD_LO)) ? CRC_INIT : crc_r;

  wfcd_crc8 u_crc (
    .crc_in  (crc_seed),
    .data_in (byte_in),
    .crc_out (crc_upd)
  );

  // direction word is held in a register, so the multiply starts there
  assign deg_prod = 25'(dir_r) * 25'(DEG_SCALE);
  assign valid    = dir_good_r & (crc_r == byte_in);

  // next state
  always_comb begin
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    low_nxt      = low_r;
    dir_nxt      = dir_r;
    spd_nxt      = spd_r;
    dir_good_nxt = dir_good_r;
    res_vld      = 1'b0;
    if (acc) begin
      unique case (pos)
        POS_DIR_LO, POS_SPD_LO: begin
          crc_nxt = crc_upd;
          low_nxt = byte_in;
          pos_nxt = pos + 3'd1;
        end
        POS_DIR_HI: begin
          crc_nxt = crc_upd;
          dir_nxt = {byte_in, low_r};
          pos_nxt = POS_DIR_CRC;
        end
        POS_DIR_CRC: begin
          dir_good_nxt = (crc_r == byte_in);
          crc_nxt      = CRC_INIT;
          pos_nxt      = POS_SPD_LO;
        end
        POS_SPD_HI: begin
          crc_nxt = crc_upd;
          spd_nxt = {byte_in, low_r};
          pos_nxt = POS_SPD_CRC;
        end
        POS_SPD_CRC: begin
          res_vld = 1'b1;
          crc_nxt = CRC_INIT;
          pos_nxt = POS_IDLE;
        end
        default: pos_nxt = POS_IDLE;
      endcase
    end
  end

  // result fields, qualified by res_vld
  always_comb begin
    res.frame_valid      = valid;
    res.direction_raw    = dir_r;
    res.direction_deg_q7 = deg_prod[DEG_SHIFT +: 16];
    res.speed_value      = spd_r;
    res.direction_update = valid & cfg.dir_en;
    res.speed_update     = valid & cfg.spd_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_DIR_LO;
      crc_r <= CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    low_r      <= low_nxt;
    dir_r      <= dir_nxt;
    spd_r      <= spd_nxt;
    dir_good_r <= dir_good_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/wfcd_skid.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfcd_skid
// Result register with one skid entry between framer and output stream.
// ----------------------------------------------------------------------------
module wfcd_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wfcd_pkg::result_t push_data,
  output logic                   can_push,
  output logic                   out_vld,
  input  wire logic              out_rdy,
  output wfcd_pkg::result_t      out_data
);
  import wfcd_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop      = main_v_r & out_rdy;
  assign can_push = ~skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      // main slot frees up: refill from skid first
      main_v_nxt = skid_v_r | push;
      main_nxt   = skid_v_r ? skid_r : push_data;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_vld  = main_v_r;
  assign out_data = main_r;

endmodule
`default_nettype wire

// ===== rtl/core/wind_frame_crc_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wind_frame_crc_decoder
// Decodes a six-byte direction/speed frame with two CRC-8 checked groups.
// ----------------------------------------------------------------------------
//  Channel  Ports        Carries
//  -------  -----------  ----------------------------------------------------
//  input    in_t*        one frame byte per transfer, start flag in tuser
//  output   out_t*       one decoded result per six-byte frame
//  config   cfg_p*       APB writes/reads of the two strobe enables
//
// One byte is taken per cycle while in_tready is high. The sixth byte's result
// is registered in the output slot, or in the skid entry if that slot is held.
// The final CRC compare and the direction-to-degrees multiply are combinational.
// Reset sets both enables and the byte position to the first byte. On a stall,
// one result waits in a skid entry; in_tready drops only while it is occupied.
// ----------------------------------------------------------------------------
module wind_frame_crc_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] byte_in
  input  wire logic                        in_tuser,   // [0] frame_start
  // output stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [15:0] direction_raw, [31:16] direction_deg_q7, [47:32] speed_value
  output logic      [wfcd_pkg::OUT_DW-1:0] out_tdata,
  // [0] frame_valid, [1] direction_update, [2] speed_update
  output logic      [wfcd_pkg::OUT_UW-1:0] out_tuser,
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [wfcd_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [wfcd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [wfcd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import wfcd_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_res;
  logic    res_vld;
  logic    can_push;
  logic    in_acc;

  assign in_tready = can_push;
  assign in_acc    = in_tvalid & in_tready;

  wfcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  wfcd_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (in_acc),
    .byte_in     (in_tdata),
    .frame_start (in_tuser),
    .cfg         (cfg),
    .res_vld     (res_vld),
    .res         (res)
  );

  wfcd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .can_push  (can_push),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_data  (out_res)
  );

  // pack result transfer
  assign out_tdata = {out_res.speed_value, out_res.direction_deg_q7, out_res.direction_raw};
  assign out_tuser = {out_res.speed_update, out_res.direction_update, out_res.frame_valid};

endmodule
`default_nettype wire

// ===== dv/wfcd_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfcd_frame_checker
// Watches the byte, result and APB channels of the wind frame CRC decoder.
// Each accepted byte is run through a local frame decoder. Each sixth byte
// queues the result that should leave the block. Result transfers are checked
// field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module wfcd_frame_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte stream, as seen at the block
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] byte_in
  input  logic                        in_tuser,   // [0] frame_start
  // result stream
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [15:0] direction_raw, [31:16] direction_deg_q7, [47:32] speed_value
  input  logic [wfcd_pkg::OUT_DW-1:0] out_tdata,
  // [0] frame_valid, [1] direction_update, [2] speed_update
  input  logic [wfcd_pkg::OUT_UW-1:0] out_tuser,
  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wfcd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [wfcd_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic                        cfg_pready,
  // to the testbench top
  output int                          pending,
  output int                          errors
);

  import wfcd_pkg::*;

  // local copy of the enables and the frame decoder state
  logic        dir_en_q;
  logic        spd_en_q;
  logic [2:0]  pos_q;
  logic [7:0]  crc_q;
  logic [7:0]  low_q;
  logic [15:0] dir_word_q;
  logic        dir_ok_q;
  logic [15:0] spd_word_q;

  // results owed by the block, oldest first
  result_t decoded_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // one byte through the CRC-8 shift network, MSB first
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++)
      c = ((c & CRC_MSB) != 0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // advance the frame decoder by one byte; the sixth byte queues a result
  function automatic void decode_byte(logic [7:0] b, logic start);
    logic [2:0]  pos;
    logic [24:0] scaled;
    result_t     r;
    pos = start ? POS_DIR_LO : pos_q;
    case (pos)
      POS_DIR_LO, POS_SPD_LO: begin
        crc_q = crc8_step(CRC_INIT, b);
        low_q = b;
        pos_q = pos + 3'd1;
      end
      POS_DIR_HI: begin
        crc_q      = crc8_step(crc_q, b);
        dir_word_q = {b, low_q};
        pos_q      = POS_DIR_CRC;
      end
      POS_DIR_CRC: begin
        dir_ok_q = (crc_q == b);
        crc_q    = CRC_INIT;
        pos_q    = POS_SPD_LO;
      end
      POS_SPD_HI: begin
        crc_q      = crc8_step(crc_q, b);
        spd_word_q = {b, low_q};
        pos_q      = POS_SPD_CRC;
      end
      POS_SPD_CRC: begin
        // 16 x 9 bit product fits in 25 bits
        scaled             = dir_word_q * DEG_SCALE;
        r.frame_valid      = dir_ok_q && (crc_q == b);
        r.direction_raw    = dir_word_q;
        r.direction_deg_q7 = 16'(scaled >> DEG_SHIFT);
        r.speed_value      = spd_word_q;
        r.direction_update = r.frame_valid & dir_en_q;
        r.speed_update     = r.frame_valid & spd_en_q;
        decoded_q.push_back(r);
        crc_q = CRC_INIT;
        pos_q = POS_IDLE;
      end
      default: pos_q = POS_IDLE;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // sample every channel at the edge where its transfer happens
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      dir_en_q   = 1'b1;
      spd_en_q   = 1'b1;
      pos_q      = POS_DIR_LO;
      crc_q      = CRC_INIT;
      low_q      = 8'h00;
      dir_word_q = 16'h0000;
      dir_ok_q   = 1'b0;
      spd_word_q = 16'h0000;
      decoded_q.delete();
    end else begin
      // result transfer: compare with the oldest owed result
      if (out_tvalid && out_tready) begin
        got = result_t'({out_tuser, out_tdata});
        if (decoded_q.size() == 0) begin
          $error("result transfer with no frame owed: tuser 0x%0h tdata 0x%0h",
                 out_tuser, out_tdata);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          check_field("frame_valid", want.frame_valid, got.frame_valid);
          check_field("direction_raw", want.direction_raw, got.direction_raw);
          check_field("direction_deg_q7", want.direction_deg_q7, got.direction_deg_q7);
          check_field("speed_value", want.speed_value, got.speed_value);
          check_field("direction_update", want.direction_update, got.direction_update);
          check_field("speed_update", want.speed_update, got.speed_update);
        end
      end
      // byte transfer
      if (in_tvalid && in_tready)
        decode_byte(in_tdata, in_tuser);
      // register write, word addressed
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[1:0] == 2'b00) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_DIR_EN: dir_en_q = cfg_pwdata[0];
          REG_SPD_EN: spd_en_q = cfg_pwdata[0];
          default: ;
        endcase
      end
    end
    pending = decoded_q.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the wind frame CRC decoder.
// Sends directed frames (extremes, bad CRCs, missing and early starts, stray
// bytes), then random frames, cut frames and noise over every enable
// setting, with random gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;

  import wfcd_pkg::*;

  localparam int N_ITEMS     = 550;
  localparam int TAIL_ITEMS  = 60;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 300;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic [OUT_UW-1:0]   out_tuser;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  int pending;
  int errors;
  int sent;

  // handoff between the byte sender and the result receiver
  bit hold_req;
  bit holding;
  bit tail;

  wind_frame_crc_decoder uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  wfcd_frame_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .errors      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // slowest clean run, with byte gaps, output stalls, the long stall and the
  // drains, still ends far inside this timeout; allow far more
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // CRC-8 of one byte, used to build frames with good check bytes
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++)
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // word with extra weight on the extremes
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // error pattern for a check byte: mostly none
  function automatic logic [7:0] rand_flip();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
  endfunction

  // one byte transfer, sometimes with a random gap ahead of it (none in the tail)
  task automatic push_byte(input logic [7:0] b, input logic start);
    if (!tail && $urandom_range(0, 11) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // first n_bytes of a frame; flip masks corrupt the check bytes
  task automatic send_frame(input logic [15:0] dir, input logic [15:0] spd,
                            input logic [7:0] dir_flip, input logic [7:0] spd_flip,
                            input bit lead_start, input int n_bytes);
    logic [7:0] fb [6];
    fb[0] = dir[7:0];
    fb[1] = dir[15:8];
    fb[2] = crc8_next(crc8_next(CRC_INIT, dir[7:0]), dir[15:8]) ^ dir_flip;
    fb[3] = spd[7:0];
    fb[4] = spd[15:8];
    fb[5] = crc8_next(crc8_next(CRC_INIT, spd[7:0]), spd[15:8]) ^ spd_flip;
    for (int i = 0; i < n_bytes; i++)
      push_byte(fb[i], lead_start && i == 0);
  endtask

  // stop sending, wait until every owed result has been taken, then settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, then access until pready
  task automatic cfg_write(input logic idx, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // result receiver: random stalls, one long hold on request, none at the end
  initial begin
    out_tready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (!tail && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // byte sender and verdict
  initial begin
    int  phase;
    int  next_cfg;
    int  sel;
    bit  held_once;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    sent      = 0;
    phase     = 0;
    held_once = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: first frame with no start after reset, extreme words
    send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 1'b0, 6);
    // bad direction check byte
    send_frame(16'h0000, 16'hFFFF, 8'h01, 8'h00, 1'b1, 6);
    // frame cut short by a new start, then a bad speed check byte
    send_frame(16'h8000, 16'h1234, 8'h00, 8'h00, 1'b1, 2);
    send_frame(16'h7FFF, 16'h00FF, 8'h00, 8'h80, 1'b1, 6);
    // stray bytes after a frame are dropped
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);

    // random part, enable settings change every phase
    next_cfg = sent;
    while (sent < N_ITEMS) begin
      tail = (sent >= N_ITEMS - TAIL_ITEMS);
      if (sent >= next_cfg) begin
        drain_results();
        // upper write bits are random and must be ignored
        cfg_write(REG_DIR_EN, {31'($urandom), phase[0]});
        cfg_write(REG_SPD_EN, {31'($urandom), phase[1]});
        phase++;
        next_cfg = sent + PHASE_ITEMS;
      end
      // long output stall while frames keep coming, then a full drain
      if (!held_once && sent >= N_ITEMS / 2) begin
        held_once = 1'b1;
        in_tvalid <= 1'b0;
        hold_req = 1'b1;
        wait (holding);
        @(posedge clk);
        repeat (5) send_frame(rand_word(), rand_word(), 8'h00, 8'h00, 1'b1, 6);
        drain_results();
      end
      sel = $urandom_range(0, 19);
      if (sel < 14)
        send_frame(rand_word(), rand_word(), rand_flip(), rand_flip(), 1'b1, 6);
      else if (sel < 16)
        send_frame(rand_word(), rand_word(), 8'h00, 8'h00, 1'b1, $urandom_range(1, 5));
      else if (sel < 18)
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), $urandom_range(0, 3) == 0);
      else
        send_frame(rand_word(), rand_word(), rand_flip(), 8'h00, 1'b0, 6);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
